[hw/rtl/b64sc_pkg.sv]
// Shared types, constants and alphabet functions for the base64 stream codec.
package b64sc_pkg;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // register index taken from paddr[2]
    localparam logic REG_MODE = 1'b0;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

    // val_of codes beyond the 6-bit range
    localparam logic [6:0] VAL_PAD = 7'd64;
    localparam logic [6:0] VAL_BAD = 7'd65;

    localparam int MAX_RES = 4;

    typedef logic [7:0] t_byte;

    // results of one item, handed from the core to the emitter
    typedef struct packed {
        logic                      valid;
        logic [2:0]                cnt;
        logic [MAX_RES-1:0][7:0]   data;
        logic                      bad;
        logic                      last;
    } t_bundle;

    function automatic t_byte sym_of(input logic [5:0] v);
        t_byte s;
        if (v < 6'd26) begin
            s = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            s = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            s = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            s = 8'h2B;
        end else begin
            s = 8'h2F;
        end
        return s;
    endfunction

    function automatic logic [6:0] val_of(input t_byte c);
        logic [6:0] v;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            v = 7'd62;
        end else if (c == 8'h2F) begin
            v = 7'd63;
        end else if (c == PAD_CHAR) begin
            v = VAL_PAD;
        end else begin
            v = VAL_BAD;
        end
        return v;
    endfunction

endpackage

[hw/rtl/b64sc_in_if.sv]
// Input item channel: a byte and an end-of-message mark.
interface b64sc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[hw/rtl/b64sc_out_if.sv]
// Result item channel: a byte, an end-of-message mark and an error flag.
interface b64sc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_char;

    modport source (output valid, output out_byte, output out_last, output bad_char,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input bad_char,
                    output ready);
endinterface

[hw/rtl/base64_stream_codec.sv]
// Top level of the base64 stream codec: mode register, core step and result buffer.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+---------------------------------
//  i_in     | in  | valid / ready   | in_byte[7:0], in_last
//  o_out    | out | valid / ready   | out_byte[7:0], out_last, bad_char
//  APB      | in  | psel / penable  | paddr[2:0], pwdata[31:0] -> prdata
//
//  An accepted item sits in the input register until the result buffer is free,
//  then its whole result list (0 to 4 results) is computed and loaded into the result buffer.
//  The first result is offered from the result buffer, and results leave one per
//  cycle while o_out is ready. The buffer takes the next item's results when it
//  is empty or as its last result leaves, so the result port sets the rate.
//  Reset (i_rst_n low, synchronous) clears mode to encode and all group state.
//  A mode write (address 0) clears group state; out-port stalls back up to i_in.
module base64_stream_codec (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    b64sc_in_if.sink                          i_in,
    b64sc_out_if.source                       o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [b64sc_pkg::APB_AW-1:0]      paddr,
    input  logic [b64sc_pkg::APB_DW-1:0]      pwdata,
    output logic [b64sc_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);
    import b64sc_pkg::*;

    logic    r_mode;
    logic    hit;
    logic    cfg_wr;
    logic    emit_free;
    t_bundle bundle;

    // one register; paddr[2] selects the word, low bits are byte lanes
    assign hit    = (paddr[2] == REG_MODE);
    assign cfg_wr = psel && penable && pwrite && hit;
    assign pready = 1'b1;
    assign prdata = hit ? {{(APB_DW-1){1'b0}}, r_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENC;
        end else if (cfg_wr) begin
            r_mode <= pwdata[0];
        end
    end

    b64sc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (cfg_wr),
        .i_mode      (r_mode),
        .i_in        (i_in),
        .i_emit_free (emit_free),
        .o_bundle    (bundle)
    );

    b64sc_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bundle (bundle),
        .o_free   (emit_free),
        .o_out    (o_out)
    );

endmodule

[hw/rtl/b64sc_core.sv]
// Input register and per-item encode/decode step with group state.
module b64sc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr,
    input  logic              i_mode,
    b64sc_in_if.sink          i_in,
    input  logic              i_emit_free,
    output b64sc_pkg::t_bundle o_bundle
);
    import b64sc_pkg::*;

    logic       r_v;
    t_byte      r_byte;
    logic       r_last;
    logic [1:0] r_phase;
    logic [5:0] r_carry;
    logic       r_halted;

    logic [1:0] n_phase;
    logic [5:0] n_carry;
    logic       n_halted;
    logic [6:0] val;
    logic       fire;
    logic       acc;
    t_bundle    bnd;

    assign fire       = r_v && i_emit_free;
    assign i_in.ready = !r_v || i_emit_free;
    assign acc        = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (acc) begin
            r_v <= 1'b1;
        end else if (fire) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_byte <= i_in.in_byte;
            r_last <= i_in.in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_phase  <= 2'd0;
            r_carry  <= 6'd0;
            r_halted <= 1'b0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_carry  <= n_carry;
            r_halted <= n_halted;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_carry    = r_carry;
        n_halted   = r_halted;
        val        = val_of(r_byte);
        bnd        = '0;
        bnd.valid  = fire;
        bnd.last   = r_last;

        if (i_mode == MODE_ENC) begin
            unique case (r_phase)
                2'd0: begin
                    bnd.data[0] = sym_of(r_byte[7:2]);
                    bnd.cnt     = 3'd1;
                    n_carry     = {r_byte[1:0], 4'b0000};
                    n_phase     = 2'd1;
                end
                2'd1: begin
                    bnd.data[0] = sym_of({r_carry[5:4], r_byte[7:4]});
                    bnd.cnt     = 3'd1;
                    n_carry     = {r_byte[3:0], 2'b00};
                    n_phase     = 2'd2;
                end
                2'd2, 2'd3: begin
                    bnd.data[0] = sym_of({r_carry[5:2], r_byte[7:6]});
                    bnd.data[1] = sym_of(r_byte[5:0]);
                    bnd.cnt     = 3'd2;
                    n_carry     = 6'd0;
                    n_phase     = 2'd0;
                end
            endcase
            // flush remainder and pad to four characters
            if (r_last) begin
                if (n_phase == 2'd1) begin
                    bnd.data[1] = sym_of(n_carry);
                    bnd.data[2] = PAD_CHAR;
                    bnd.data[3] = PAD_CHAR;
                    bnd.cnt     = 3'd4;
                end else if (n_phase == 2'd2) begin
                    bnd.data[1] = sym_of(n_carry);
                    bnd.data[2] = PAD_CHAR;
                    bnd.cnt     = 3'd3;
                end
            end
        end else if (!r_halted) begin
            if (val == VAL_PAD) begin
                n_halted = 1'b1;
            end else if (val == VAL_BAD) begin
                bnd.cnt  = 3'd1;
                bnd.bad  = 1'b1;
                n_halted = 1'b1;
            end else begin
                unique case (r_phase)
                    2'd0: begin
                        n_carry = val[5:0];
                        n_phase = 2'd1;
                    end
                    2'd1: begin
                        bnd.data[0] = {r_carry, val[5:4]};
                        bnd.cnt     = 3'd1;
                        n_carry     = {2'b00, val[3:0]};
                        n_phase     = 2'd2;
                    end
                    2'd2: begin
                        bnd.data[0] = {r_carry[3:0], val[5:2]};
                        bnd.cnt     = 3'd1;
                        n_carry     = {4'b0000, val[1:0]};
                        n_phase     = 2'd3;
                    end
                    2'd3: begin
                        bnd.data[0] = {r_carry[1:0], val[5:0]};
                        bnd.cnt     = 3'd1;
                        n_carry     = 6'd0;
                        n_phase     = 2'd0;
                    end
                endcase
            end
        end

        if (r_last) begin
            n_phase  = 2'd0;
            n_carry  = 6'd0;
            n_halted = 1'b0;
        end
    end

    assign o_bundle = bnd;

`ifndef SYNTHESIS
    a_enc_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_mode == MODE_ENC) |-> (bnd.cnt != 3'd0))
        else $error("encode item produced no result");
    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_mode == MODE_DEC && r_halted) |-> (bnd.cnt == 3'd0))
        else $error("halted decoder produced a result");
    a_enc_not_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_mode == MODE_ENC) |-> !r_halted)
        else $error("halted flag set in encode mode");
`endif

endmodule

[hw/rtl/b64sc_emit.sv]
// Result buffer: holds one item's results and sends them one per cycle while o_out is ready.
module b64sc_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b64sc_pkg::t_bundle i_bundle,
    output logic               o_free,
    b64sc_out_if.source        o_out
);
    import b64sc_pkg::*;

    logic [2:0]              r_cnt;
    logic [MAX_RES-1:0][7:0] r_data;
    logic                    r_last;
    logic                    r_bad;
    logic                    pop;

    assign pop    = o_out.valid && o_out.ready;
    assign o_free = (r_cnt == 3'd0) || (r_cnt == 3'd1 && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_bundle.valid) begin
            r_cnt <= i_bundle.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bundle.valid) begin
            r_data <= i_bundle.data;
            r_last <= i_bundle.last;
            r_bad  <= i_bundle.bad;
        end else if (pop) begin
            r_data <= {8'h00, r_data[MAX_RES-1:1]};
        end
    end

    assign o_out.valid    = (r_cnt != 3'd0);
    assign o_out.out_byte = r_data[0];
    assign o_out.out_last = r_last && (r_cnt == 3'd1);
    assign o_out.bad_char = r_bad;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bundle.valid |-> o_free)
        else $error("results loaded over pending results");
    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_cnt > 3'd1) |=> (r_cnt == $past(r_cnt) - 3'd1))
        else $error("result count skipped");
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 3'd0 && r_bad) |-> (r_cnt == 3'd1))
        else $error("error result not alone");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result count out of range");
`endif

endmodule

[verif/tb_base64_stream_codec.sv]
`timescale 1ns / 1ps
// Testbench for base64_stream_codec: directed table, random messages, scoreboard.
module tb_base64_stream_codec;
    import b64sc_pkg::*;

    // Slowest legal run: up to 160 items, up to 4 results each, receiver idle 78% of
    // cycles, sender idle 78% in one phase, plus drains around every register
    // write. CYCLE_LIMIT is well above what such a run needs.
    localparam int CYCLE_LIMIT   = 300000;
    // An item passes the input register and the result buffer; wait_idle also waits
    // after the last owed result so an item that gives no result has surely left the block.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;   // long receiver stall to back up i_in
    localparam int PHASE_ITEMS   = 30;   // random items per idling phase
    localparam int DIR_ROWS      = 28;

    // register map: register i at byte address 4*i, index in paddr[2]
    localparam logic [APB_AW-1:0] ADDR_MODE  = {REG_MODE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPARE = {~REG_MODE, 2'b00};

    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_Z = "Z";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_Z = "z";
    localparam logic [7:0] CH_DIGIT_0 = "0";
    localparam logic [7:0] CH_DIGIT_9 = "9";
    localparam logic [7:0] CH_PLUS    = "+";
    localparam logic [7:0] CH_SLASH   = "/";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_codec_res;

    typedef enum logic [1:0] {ROW_ITEM, ROW_MODE, ROW_SPARE} t_row_kind;

    // One row of the directed table. Typed rows carry their results in res,
    // first result in res[3]; the others take the results from the predictor.
    typedef struct packed {
        t_row_kind       kind;
        logic [7:0]      val;     // item byte, or register write data
        logic            last;
        logic            typed;
        logic [2:0]      n_res;
        logic [3:0][7:0] res;
        logic            bad;
    } t_stim_row;

    localparam t_stim_row DIR_TAB [0:DIR_ROWS-1] = '{
        // encode, straight out of reset
        '{ROW_ITEM,  8'h00, 1'b1, 1'b1, 3'd4, "AA==", 1'b0},  // one byte -> "=="
        '{ROW_ITEM,  8'hFF, 1'b1, 1'b1, 3'd4, "/w==", 1'b0},
        '{ROW_ITEM,  "M",   1'b0, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_ITEM,  "a",   1'b0, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_ITEM,  "n",   1'b1, 1'b0, 3'd0, '0,     1'b0},  // full group, no pad
        '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_ITEM,  8'hFF, 1'b1, 1'b0, 3'd0, '0,     1'b0},  // two bytes -> "="
        '{ROW_ITEM,  8'h12, 1'b0, 1'b0, 3'd0, '0,     1'b0},  // left open
        // mode write abandons the open message
        '{ROW_MODE,  8'(MODE_DEC), 1'b0, 1'b0, 3'd0, '0, 1'b0},
        '{ROW_ITEM,  "T",   1'b0, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_ITEM,  "W",   1'b0, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_ITEM,  "F",   1'b0, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_ITEM,  "u",   1'b1, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_ITEM,  "/",   1'b0, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_ITEM,  "+",   1'b0, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_ITEM,  "=",   1'b1, 1'b0, 3'd0, '0,     1'b0},  // pad ends it, no last
        '{ROW_ITEM,  "A",   1'b1, 1'b0, 3'd0, '0,     1'b0},  // lone char, silent
        '{ROW_ITEM,  "*",   1'b1, 1'b1, 3'd1, '0,     1'b1},  // bad char as last
        '{ROW_ITEM,  8'h80, 1'b0, 1'b1, 3'd1, '0,     1'b1},  // high byte is bad
        '{ROW_ITEM,  "A",   1'b0, 1'b1, 3'd0, '0,     1'b0},  // halted: dropped
        '{ROW_ITEM,  8'hFF, 1'b1, 1'b1, 3'd0, '0,     1'b0},  // halted: dropped
        '{ROW_ITEM,  8'hFF, 1'b1, 1'b1, 3'd1, '0,     1'b1},  // fresh message
        '{ROW_ITEM,  "Q",   1'b0, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_ITEM,  "Q",   1'b1, 1'b0, 3'd0, '0,     1'b0},  // leftover bits dropped
        // write to an unmapped address must not touch the mode
        '{ROW_SPARE, 8'(MODE_ENC), 1'b0, 1'b0, 3'd0, '0, 1'b0},
        '{ROW_ITEM,  "0",   1'b0, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_ITEM,  "9",   1'b1, 1'b0, 3'd0, '0,     1'b0},
        '{ROW_MODE,  8'(MODE_ENC), 1'b0, 1'b0, 3'd0, '0, 1'b0}
    };

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    b64sc_in_if  in_ch ();
    b64sc_out_if out_ch ();

    base64_stream_codec dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic       cur_mode;
    logic [1:0] grp_phase;
    logic [5:0] pend_bits;
    logic       dec_halted;

    t_codec_res step_out [$];   // results of the item just accepted
    t_codec_res out_due_q [$];  // results still owed by the block

    int send_idle_pct = 15;
    int recv_idle_pct = 78;
    logic hold_req  = 1'b0;
    int hold_left   = 0;
    int cycle_cnt   = 0;
    int fail_cnt    = 0;
    int items_sent  = 0;
    int res_checked = 0;
    int enc_msgs    = 0;
    int dec_msgs    = 0;
    int cfg_writes  = 0;

    initial begin : clock_gen
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 6'd26) return CH_UPPER_A + 8'(v);
        if (v < 6'd52) return CH_LOWER_A + 8'(v - 6'd26);
        if (v < 6'd62) return CH_DIGIT_0 + 8'(v - 6'd52);
        return (v == 6'd62) ? CH_PLUS : CH_SLASH;
    endfunction

    // 0..63 for alphabet chars, VAL_PAD for '=', VAL_BAD for anything else
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return 7'(c - CH_UPPER_A);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return 7'(c - CH_LOWER_A + 8'd26);
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return 7'(c - CH_DIGIT_0 + 8'd52);
        if (c == CH_PLUS) return 7'd62;
        if (c == CH_SLASH) return 7'd63;
        if (c == PAD_CHAR) return VAL_PAD;
        return VAL_BAD;
    endfunction

    function automatic void drop_message();
        grp_phase  = 2'd0;
        pend_bits  = '0;
        dec_halted = 1'b0;
    endfunction

    function automatic void add_res(input logic [7:0] b, input logic bad);
        step_out.push_back('{b, 1'b0, bad});
    endfunction

    // Results that one accepted item causes, left in step_out.
    function automatic void b64_codec_step(input logic [7:0] c, input logic l);
        logic [6:0] v;
        t_codec_res tail;
        step_out.delete();
        if (cur_mode == MODE_ENC) begin
            case (grp_phase)
                2'd0: begin
                    add_res(b64_char(c[7:2]), 1'b0);
                    pend_bits = {c[1:0], 4'd0};
                    grp_phase = 2'd1;
                end
                2'd1: begin
                    add_res(b64_char(pend_bits | {2'd0, c[7:4]}), 1'b0);
                    pend_bits = {c[3:0], 2'd0};
                    grp_phase = 2'd2;
                end
                default: begin
                    add_res(b64_char(pend_bits | {4'd0, c[7:6]}), 1'b0);
                    add_res(b64_char(c[5:0]), 1'b0);
                    pend_bits = '0;
                    grp_phase = 2'd0;
                end
            endcase
            // flush zero-padded remainder, then '=' up to a 4-char boundary
            if (l && grp_phase != 2'd0) begin
                add_res(b64_char(pend_bits), 1'b0);
                repeat (3 - grp_phase) add_res(PAD_CHAR, 1'b0);
            end
        end else if (!dec_halted) begin
            v = b64_value(c);
            if (v == VAL_PAD) begin
                dec_halted = 1'b1;
            end else if (v == VAL_BAD) begin
                add_res(8'd0, 1'b1);
                dec_halted = 1'b1;
            end else begin
                case (grp_phase)
                    2'd0: begin
                        pend_bits = v[5:0];
                        grp_phase = 2'd1;
                    end
                    2'd1: begin
                        add_res({pend_bits, v[5:4]}, 1'b0);
                        pend_bits = {2'd0, v[3:0]};
                        grp_phase = 2'd2;
                    end
                    2'd2: begin
                        add_res({pend_bits[3:0], v[5:2]}, 1'b0);
                        pend_bits = {4'd0, v[1:0]};
                        grp_phase = 2'd3;
                    end
                    default: begin
                        add_res({pend_bits[1:0], v[5:0]}, 1'b0);
                        pend_bits = '0;
                        grp_phase = 2'd0;
                    end
                endcase
            end
        end
        if (l) begin
            if (step_out.size() > 0) begin
                tail = step_out.pop_back();
                tail.last = 1'b1;
                step_out.push_back(tail);
            end
            drop_message();
        end
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------
    // Offer one item; valid stays high after acceptance so back-to-back items
    // never lower and raise it in the same step.
    task automatic send_item(input t_stim_row row);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= row.val;
        in_ch.in_last <= row.last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        b64_codec_step(row.val, row.last);
        if (row.typed) begin
            for (int k = 0; k < row.n_res; k++) begin
                out_due_q.push_back('{row.res[3-k], row.last && (k == row.n_res - 1),
                                      row.bad});
            end
        end else begin
            foreach (step_out[k]) out_due_q.push_back(step_out[k]);
        end
        items_sent++;
    endtask

    // Drop valid, wait for every owed result, then let stragglers settle.
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (out_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Register write on an idle block, then read the mode back.
    task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [7:0] val);
        logic [APB_DW-1:0] rd;
        wait_idle();
        apb_xfer(1'b1, addr, {{(APB_DW-8){1'b0}}, val}, rd);
        if (addr == ADDR_MODE) begin
            cur_mode = val[0];
            drop_message();
        end
        apb_xfer(1'b0, ADDR_MODE, '0, rd);
        if (rd !== {{(APB_DW-1){1'b0}}, cur_mode}) begin
            $error("prdata: expected %h, got %h", {{(APB_DW-1){1'b0}}, cur_mode}, rd);
            fail_cnt++;
        end
        cfg_writes++;
    endtask

    // ---------------------------------------------------------------------
    // Result side: random ready, plus a long hold-off on request
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin : result_sink
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Scoreboard: every accepted result against the oldest owed one.
    always @(posedge i_clk) begin : result_check
        t_codec_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (out_due_q.size() == 0) begin
                $error("unexpected result: out_byte %h out_last %b bad_char %b",
                       out_ch.out_byte, out_ch.out_last, out_ch.bad_char);
                fail_cnt++;
            end else begin
                want = out_due_q.pop_front();
                res_checked++;
                if (out_ch.out_byte !== want.data) begin
                    $error("out_byte: expected %h, got %h", want.data, out_ch.out_byte);
                    fail_cnt++;
                end
                if (out_ch.out_last !== want.last) begin
                    $error("out_last: expected %b, got %b", want.last, out_ch.out_last);
                    fail_cnt++;
                end
                if (out_ch.bad_char !== want.bad) begin
                    $error("bad_char: expected %b, got %b", want.bad, out_ch.bad_char);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_cnt, out_due_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row  row;
        logic [7:0] msg [$];
        int         n_len;
        int         pos;
        int         phase_items;
        int         msg_idx;
        logic       pressure;

        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        cur_mode      = MODE_ENC;
        drop_message();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (DIR_TAB[i]) begin
            case (DIR_TAB[i].kind)
                ROW_ITEM: send_item(DIR_TAB[i]);
                ROW_MODE: cfg_write(ADDR_MODE, DIR_TAB[i].val);
                default:  cfg_write(ADDR_SPARE, DIR_TAB[i].val);
            endcase
        end

        // random messages in three idling phases: slow receiver, slow sender,
        // then full rate
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_items = 0;
            msg_idx     = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 30)
                    cfg_write(ADDR_MODE, $urandom_range(0, 1) ? 8'(MODE_DEC) : 8'(MODE_ENC));
                // sender pauses until the block has drained
                if (msg_idx == 3) wait_idle();
                // at full rate, stall the output while a long message keeps coming
                pressure = (p == 2 && msg_idx == 1);
                if (pressure) hold_req = 1'b1;

                msg.delete();
                if (cur_mode == MODE_ENC) begin
                    n_len = pressure ? 12 : $urandom_range(1, 7);
                    repeat (n_len) msg.push_back(8'($urandom_range(0, 255)));
                    enc_msgs++;
                end else begin
                    n_len = pressure ? 16 : $urandom_range(2, 12);
                    repeat (n_len) msg.push_back(b64_char(6'($urandom_range(0, 63))));
                    case ($urandom_range(0, 9))
                        0: begin
                            // plain noise
                            foreach (msg[j]) msg[j] = 8'($urandom_range(0, 255));
                        end
                        1, 2: begin
                            // one spoiled char: early pad or arbitrary byte
                            pos = $urandom_range(0, n_len - 1);
                            msg[pos] = $urandom_range(0, 1) ? PAD_CHAR
                                                            : 8'($urandom_range(0, 255));
                        end
                        default: begin
                            if (msg.size() % 4 > 1)
                                repeat (4 - msg.size() % 4) msg.push_back(PAD_CHAR);
                        end
                    endcase
                    dec_msgs++;
                end

                foreach (msg[j]) begin
                    row = '{ROW_ITEM, msg[j], 1'(j == msg.size() - 1), 1'b0, 3'd0, '0, 1'b0};
                    send_item(row);
                end
                phase_items += msg.size();
                msg_idx++;
            end
        end

        wait_idle();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);

        $display("ran %0d items in %0d encode and %0d decode random messages, %0d results",
                 items_sent, enc_msgs, dec_msgs, res_checked);
        $display("with %0d register writes, long output stall, pad and bad-char cases",
                 cfg_writes);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[base64_stream_codec.f]
hw/rtl/b64sc_pkg.sv
hw/rtl/b64sc_in_if.sv
hw/rtl/b64sc_out_if.sv
hw/rtl/b64sc_core.sv
hw/rtl/b64sc_emit.sv
hw/rtl/base64_stream_codec.sv
verif/tb_base64_stream_codec.sv
